// ===== design/hsv2rgb_pkg.sv =====
// Shared types and constants for the HSV to RGB pixel converter.
// No dependencies; imported by hsv_to_rgb_converter.
package hsv2rgb_pkg;

  // Hue scale: degrees with 6 fraction bits
  localparam logic [14:0] HueFull   = 15'd23040;  // 360 degrees
  localparam logic [11:0] HueSector = 12'd3840;   // 60 degrees

  // Denominator of q and t: 255 * 3840
  localparam logic [19:0] QtDenom = 20'd979200;

  // Reciprocal multipliers; both give exact floors over their input range.
  // p: floor(x / 255) = (x * PMult) >> PShift, x < 2^16
  localparam int unsigned PShift = 24;
  localparam logic [16:0] PMult  = 17'(((64'd1 << PShift) + 64'd254) / 64'd255);
  // q, t: floor(y / 3825) = (y * QtMult) >> QtShift, y < 2^20
  localparam int unsigned QtShift = 32;
  localparam logic [20:0] QtMult  = 21'(((64'd1 << QtShift) + 64'd3824) / 64'd3825);

  // Sixty-degree hue sectors
  typedef enum logic [2:0] {
    SecRed     = 3'd0,
    SecYellow  = 3'd1,
    SecGreen   = 3'd2,
    SecCyan    = 3'd3,
    SecBlue    = 3'd4,
    SecMagenta = 3'd5
  } sector_e;

  // Hue at the start of a sector
  function automatic logic [14:0] sector_base(input sector_e sec);
    logic [14:0] base;
    case (sec)
      SecRed:     base = 15'd0;
      SecYellow:  base = 15'd3840;
      SecGreen:   base = 15'd7680;
      SecCyan:    base = 15'd11520;
      SecBlue:    base = 15'd15360;
      SecMagenta: base = 15'd19200;
      default:    base = 15'd0;
    endcase
    return base;
  endfunction

endpackage

// ===== design/hsv_to_rgb_converter.sv =====
// HSV to RGB pixel converter, five-stage pipeline with stream handshakes.
// Depends on hsv2rgb_pkg for constants, the sector type and sector_base().

// One pixel enters per clock; a stall on the
// output side holds the pipeline, while bubbles still close up, so no beat is
// lost or repeated. Stage 3 multiplies saturation by hue position, stage 4
// multiplies brightness by the scaled term, and the constant divisions are
// done by reciprocal multiplies in stages 4 and 5; each is one register
// stage. Hue at or above 360 degrees wraps once. Zero saturation gives gray.
// Alpha passes through unchanged.
module hsv_to_rgb_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beat: [14:0] hue, [22:15] saturation, [30:23] brightness,
  // [38:31] alpha_in, [39] zero pad
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  // output beat: [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha_out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata
);
  import hsv2rgb_pkg::*;

  // Stage valids and handshake chain
  logic vld1_q, vld2_q, vld3_q, vld4_q, vld5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = ~vld5_q | m_axis_tready;
  assign rdy4 = ~vld4_q | rdy5;
  assign rdy3 = ~vld3_q | rdy4;
  assign rdy2 = ~vld2_q | rdy3;
  assign rdy1 = ~vld1_q | rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
    end else begin
      if (rdy1) vld1_q <= s_axis_tvalid;
      if (rdy2) vld2_q <= vld1_q;
      if (rdy3) vld3_q <= vld2_q;
      if (rdy4) vld4_q <= vld3_q;
      if (rdy5) vld5_q <= vld4_q;
    end
  end

  // Input fields
  logic [14:0] hue_in;
  logic [7:0]  sat_in, val_in, alpha_in;
  assign hue_in   = s_axis_tdata[14:0];
  assign sat_in   = s_axis_tdata[22:15];
  assign val_in   = s_axis_tdata[30:23];
  assign alpha_in = s_axis_tdata[38:31];

  // Stage 1: wrap hue into one turn
  logic [14:0] hue1_d, hue1_q;
  logic [7:0]  sat1_q, val1_q, alpha1_q;
  assign hue1_d = (hue_in >= HueFull) ? hue_in - HueFull : hue_in;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      hue1_q   <= hue1_d;
      sat1_q   <= sat_in;
      val1_q   <= val_in;
      alpha1_q <= alpha_in;
    end
  end

  // Stage 2: sector and position within the sector
  sector_e     sec2_d, sec2_q;
  logic [14:0] pos2_full;
  logic [11:0] pos2_q;
  logic [7:0]  sat2_q, val2_q, alpha2_q;

  always_comb begin
    if (hue1_q >= 15'd19200)      sec2_d = SecMagenta;
    else if (hue1_q >= 15'd15360) sec2_d = SecBlue;
    else if (hue1_q >= 15'd11520) sec2_d = SecCyan;
    else if (hue1_q >= 15'd7680)  sec2_d = SecGreen;
    else if (hue1_q >= 15'd3840)  sec2_d = SecYellow;
    else                          sec2_d = SecRed;
  end
  assign pos2_full = hue1_q - sector_base(sec2_d);

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      sec2_q   <= sec2_d;
      pos2_q   <= pos2_full[11:0];
      sat2_q   <= sat1_q;
      val2_q   <= val1_q;
      alpha2_q <= alpha1_q;
    end
  end

  // Stage 3: saturation products and the p numerator
  logic [11:0] rest3;
  logic [19:0] sf3_d, sg3_d, sf3_q, sg3_q;
  logic [15:0] pn3_d, pn3_q;
  logic [7:0]  inv_sat3;
  sector_e     sec3_q;
  logic [11:0] pos3_q;
  logic [7:0]  val3_q, alpha3_q;
  logic        gray3_q;

  assign rest3    = HueSector - pos2_q;
  assign inv_sat3 = 8'd255 - sat2_q;
  assign sf3_d    = {12'd0, sat2_q} * {8'd0, pos2_q};
  assign sg3_d    = {12'd0, sat2_q} * {8'd0, rest3};
  assign pn3_d    = {8'd0, val2_q} * {8'd0, inv_sat3};

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      sf3_q    <= sf3_d;
      sg3_q    <= sg3_d;
      pn3_q    <= pn3_d;
      sec3_q   <= sec2_q;
      pos3_q   <= pos2_q;
      val3_q   <= val2_q;
      alpha3_q <= alpha2_q;
      gray3_q  <= (sat2_q == 8'd0);
    end
  end

  // Stage 4: brightness times scaled terms, p by reciprocal
  logic [19:0] nq4, nt4;
  logic [27:0] xq4_d, xt4_d, xq4_q, xt4_q;
  logic [32:0] pp4;
  logic [7:0]  p4_q;
  sector_e     sec4_q;
  logic [7:0]  val4_q, alpha4_q;
  logic        gray4_q;

  assign nq4   = QtDenom - sf3_q;
  assign nt4   = QtDenom - sg3_q;
  assign xq4_d = {20'd0, val3_q} * {8'd0, nq4};
  assign xt4_d = {20'd0, val3_q} * {8'd0, nt4};
  assign pp4   = {17'd0, pn3_q} * {16'd0, PMult};

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      xq4_q    <= xq4_d;
      xt4_q    <= xt4_d;
      p4_q     <= pp4[PShift +: 8];
      sec4_q   <= sec3_q;
      val4_q   <= val3_q;
      alpha4_q <= alpha3_q;
      gray4_q  <= gray3_q;
    end
  end

  // Stage 5: divide by 979200 (shift by 8, then reciprocal of 3825), route
  logic [40:0] qp5, tp5;
  logic [7:0]  q5, t5;
  logic [7:0]  red5_d, grn5_d, blu5_d;
  logic [7:0]  red5_q, grn5_q, blu5_q, alpha5_q, val5_q;
  logic        gray5_q;

  assign qp5 = {21'd0, xq4_q[27:8]} * {20'd0, QtMult};
  assign tp5 = {21'd0, xt4_q[27:8]} * {20'd0, QtMult};
  assign q5  = qp5[QtShift +: 8];
  assign t5  = tp5[QtShift +: 8];

  always_comb begin
    red5_d = val4_q;
    grn5_d = val4_q;
    blu5_d = val4_q;
    if (!gray4_q) begin
      case (sec4_q)
        SecRed:     begin red5_d = val4_q; grn5_d = t5;     blu5_d = p4_q;   end
        SecYellow:  begin red5_d = q5;     grn5_d = val4_q; blu5_d = p4_q;   end
        SecGreen:   begin red5_d = p4_q;   grn5_d = val4_q; blu5_d = t5;     end
        SecCyan:    begin red5_d = p4_q;   grn5_d = q5;     blu5_d = val4_q; end
        SecBlue:    begin red5_d = t5;     grn5_d = p4_q;   blu5_d = val4_q; end
        default:    begin red5_d = val4_q; grn5_d = p4_q;   blu5_d = q5;     end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      red5_q   <= red5_d;
      grn5_q   <= grn5_d;
      blu5_q   <= blu5_d;
      alpha5_q <= alpha4_q;
      val5_q   <= val4_q;
      gray5_q  <= gray4_q;
    end
  end

  assign m_axis_tvalid = vld5_q;
  assign m_axis_tdata  = {alpha5_q, blu5_q, grn5_q, red5_q};

  // Checks
  a_pos_in_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld3_q |-> (pos3_q < HueSector))
    else $error("hue position outside its sector");

  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld5_q && gray5_q) |-> (red5_q == val5_q && grn5_q == val5_q && blu5_q == val5_q))
    else $error("zero saturation did not give gray");

  a_max_is_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld5_q |-> (red5_q == val5_q || grn5_q == val5_q || blu5_q == val5_q))
    else $error("no channel equals brightness");

  a_not_above_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld5_q |-> (red5_q <= val5_q && grn5_q <= val5_q && blu5_q <= val5_q))
    else $error("channel above brightness");

  a_stall_backs_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld1_q && vld2_q && vld3_q && vld4_q && vld5_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("full pipeline took a beat while stalled");

endmodule

// ===== dv/tb_top.sv =====
// Testbench for hsv_to_rgb_converter: random and directed pixels, scoreboard with its own predictor.
// Depends on hsv2rgb_pkg (hue constants, sector type) and the converter RTL.
`timescale 1ns / 1ps

module tb_top;
  import hsv2rgb_pkg::*;

  // Input beat, last field in the lowest bits
  typedef struct packed {
    logic       pad;
    logic [7:0] alpha;
    logic [7:0] value;
    logic [7:0] sat;
    logic [14:0] hue;
  } hsva_t;

  // Output beat, red in the lowest byte
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  // Holds the colors still owed by the converter, in order
  class color_scoreboard;
    rgba_t       owed_colors[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Fixed-point HSV to RGB, truncating divisions
    function rgba_t convert_pixel(hsva_t px);
      longint unsigned hue_deg, hue_pos, s, v, p, q, t, denom;
      sector_e         sec;
      rgba_t           c;
      hue_deg = px.hue;
      if (hue_deg >= HueFull) hue_deg = hue_deg - HueFull;  // wrap once past 360
      sec     = sector_e'(3'(hue_deg / HueSector));
      hue_pos = hue_deg % HueSector;
      s       = px.sat;
      v       = px.value;
      denom   = QtDenom;
      p = (v * (255 - s)) / 255;
      q = (v * (denom - s * hue_pos)) / denom;
      t = (v * (denom - s * (HueSector - hue_pos))) / denom;
      c.alpha = px.alpha;
      if (s == 0) begin
        // gray
        c.red = 8'(v); c.green = 8'(v); c.blue = 8'(v);
      end else begin
        case (sec)
          SecRed: begin
            c.red = 8'(v); c.green = 8'(t); c.blue = 8'(p);
          end
          SecYellow: begin
            c.red = 8'(q); c.green = 8'(v); c.blue = 8'(p);
          end
          SecGreen: begin
            c.red = 8'(p); c.green = 8'(v); c.blue = 8'(t);
          end
          SecCyan: begin
            c.red = 8'(p); c.green = 8'(q); c.blue = 8'(v);
          end
          SecBlue: begin
            c.red = 8'(t); c.green = 8'(p); c.blue = 8'(v);
          end
          default: begin
            c.red = 8'(v); c.green = 8'(p); c.blue = 8'(q);
          end
        endcase
      end
      return c;
    endfunction

    function void note_pixel(hsva_t px);
      owed_colors.push_back(convert_pixel(px));
    endfunction

    function int pending();
      return owed_colors.size();
    endfunction

    // One line per mismatch, and a count
    task report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_color(input rgba_t got);
      rgba_t want;
      if (owed_colors.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h", got));
        return;
      end
      want = owed_colors.pop_front();
      if (got.red != want.red)
        report_mismatch($sformatf("red %0d, want %0d", got.red, want.red));
      if (got.green != want.green)
        report_mismatch($sformatf("green %0d, want %0d", got.green, want.green));
      if (got.blue != want.blue)
        report_mismatch($sformatf("blue %0d, want %0d", got.blue, want.blue));
      if (got.alpha != want.alpha)
        report_mismatch($sformatf("alpha %0d, want %0d", got.alpha, want.alpha));
    endtask

    task check_drained();
      if (owed_colors.size() != 0)
        report_mismatch($sformatf("%0d colors never arrived", owed_colors.size()));
    endtask
  endclass

  localparam int unsigned CycleLimit = 50000;
  localparam int unsigned HoldCycles = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  color_scoreboard sb = new();

  // Idling controls for the sender and receiver processes, and the watchdog count
  logic        tx_steady;
  logic        rx_steady;
  logic        hold_req;
  int unsigned cycles;

  hsv_to_rgb_converter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Beat monitors
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_pixel(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_color(m_axis_tdata);
  end

  // Receiver: random stalls, steady stretches, and one long hold-off on request
  initial begin
    logic hold_done;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end else if (rx_steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 20);
      end
    end
  end

  function automatic hsva_t make_pixel(int unsigned h, int unsigned s, int unsigned v,
                                       int unsigned a);
    hsva_t px;
    px.pad = 1'b0;
    px.hue = 15'(h);
    px.sat = 8'(s);
    px.value = 8'(v);
    px.alpha = 8'(a);
    return px;
  endfunction

  // Bias toward zero and full scale
  function automatic logic [7:0] pick_level();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'd0;
    if (roll == 1) return 8'd255;
    return 8'($urandom);
  endfunction

  function automatic hsva_t random_pixel();
    hsva_t       px;
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6)
      px.hue = 15'($urandom_range(0, HueFull - 1));
    else if (roll == 6)
      px.hue = 15'($urandom_range(HueFull, 32767));
    else if (roll == 7)  // sector edges
      px.hue = 15'($urandom_range(0, 5) * HueSector + ($urandom_range(0, 1) ? HueSector - 1 : 0));
    else
      px.hue = 15'($urandom);
    px.sat   = pick_level();
    px.value = pick_level();
    px.alpha = 8'($urandom);
    px.pad   = 1'b0;
    return px;
  endfunction

  // Enters and leaves at a falling edge; valid stays up unless a gap is taken
  task automatic send_pixel(input hsva_t px);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (!tx_steady && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk_i);
    end
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pixel(random_pixel());
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    hold_req      = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: sector starts and ends, hue wrap, gray, black, full scale
    send_pixel(make_pixel(0, 255, 255, 255));      // full saturation at sector start
    send_pixel(make_pixel(0, 0, 0, 0));
    send_pixel(make_pixel(3839, 255, 255, 0));
    send_pixel(make_pixel(3840, 255, 255, 128));
    send_pixel(make_pixel(7680, 200, 180, 1));
    send_pixel(make_pixel(11520, 255, 255, 255));
    send_pixel(make_pixel(15360, 128, 77, 200));
    send_pixel(make_pixel(19200, 255, 255, 255));
    send_pixel(make_pixel(23039, 255, 255, 255));  // last legal hue
    send_pixel(make_pixel(23040, 255, 200, 10));   // wraps to zero
    send_pixel(make_pixel(32767, 255, 255, 255));  // largest field value
    send_pixel(make_pixel(26880, 100, 100, 100));  // wraps into yellow
    send_pixel(make_pixel(5000, 0, 200, 50));      // gray
    send_pixel(make_pixel(12345, 0, 255, 255));
    send_pixel(make_pixel(1920, 255, 0, 90));      // black
    send_pixel(make_pixel(9600, 1, 255, 3));
    send_pixel(make_pixel(17000, 254, 254, 254));
    send_pixel(make_pixel(21000, 255, 128, 77));
    send_pixel(make_pixel(2000, 128, 255, 255));
    send_pixel(make_pixel(13440, 255, 1, 0));

    send_random(300);

    // No idling on either side
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    send_random(200);
    rx_steady = 1'b0;

    // Sender pauses until the pipeline has drained
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);

    // Receiver holds off while the sender keeps offering, so the input stalls
    hold_req = 1'b1;
    send_random(100);
    tx_steady = 1'b0;

    send_random(330);

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    sb.check_drained();
    if (sb.mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
